// ===== src/oet_pkg.sv =====
// shared types, codes and stream field layout for the ordered entry table
// no dependencies; used by oet_cell, oet_or_tree and ordered_entry_table
package oet_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int ENTRY_BITS_DEF = 32;

    localparam int MODE_W     = 2;
    localparam int POS_W      = 8;
    localparam int IN_DATA_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 6;
    localparam int RD_DATA_W  = 32;
    localparam int FILL_W     = 7;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic ins;
        logic rem;
        logic rd;
    } t_cell_ctrl;

    function automatic int tree_levels(input int n);
        int l;
        l = ($clog2(n) + 1) / 2;
        if (l < 1) l = 1;
        return l;
    endfunction

endpackage

// ===== src/oet_cell.sv =====
// one entry cell of the table chain: shifts from either neighbor or loads new data
// depends on oet_pkg
module oet_cell
    import oet_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int W     = 32,
    parameter int K     = 0
) (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [IDX_W-1:0] i_wr_pos,
    input  logic [IDX_W-1:0] i_rd_pos,
    input  logic [W-1:0]     i_data,
    input  logic [W-1:0]     i_left,
    input  logic [W-1:0]     i_right,
    output logic [W-1:0]     o_q,
    output logic [W-1:0]     o_rd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(K);

    logic [W-1:0] r_q;
    logic [W-1:0] n_q;

    always_comb begin
        priority if (i_ctrl.ins && MY_IDX > i_wr_pos) begin
            n_q = i_left;
        end else if (i_ctrl.ins && MY_IDX == i_wr_pos) begin
            n_q = i_data;
        end else if (i_ctrl.rem && MY_IDX >= i_wr_pos) begin
            n_q = i_right;
        end else begin
            n_q = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q  = r_q;
    assign o_rd = (i_ctrl.rd && i_rd_pos == MY_IDX) ? r_q : '0;

endmodule

// ===== src/oet_or_tree.sv =====
// registered radix-4 or-reduction of the masked cell read outputs
// depends on oet_pkg
module oet_or_tree
    import oet_pkg::*;
#(
    parameter int N = 64,
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_leaf [N],
    output logic [W-1:0] o_sum
);

    localparam int LV  = tree_levels(N);
    localparam int PAD = 1 << (2 * LV);

    logic [W-1:0] w_leaf [PAD];
    logic [W-1:0] r_node [LV][PAD/4];

    for (genvar gi = 0; gi < PAD; gi++) begin : g_leaf
        if (gi < N) begin : g_real
            assign w_leaf[gi] = i_leaf[gi];
        end else begin : g_pad
            assign w_leaf[gi] = '0;
        end
    end

    for (genvar gl = 0; gl < LV; gl++) begin : g_lvl
        for (genvar gn = 0; gn < (PAD >> (2 * (gl + 1))); gn++) begin : g_node
            if (gl == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    r_node[0][gn] <= w_leaf[4*gn] | w_leaf[4*gn+1]
                                   | w_leaf[4*gn+2] | w_leaf[4*gn+3];
                end
            end else begin : g_upper
                always_ff @(posedge i_clk) begin
                    r_node[gl][gn] <= r_node[gl-1][4*gn] | r_node[gl-1][4*gn+1]
                                    | r_node[gl-1][4*gn+2] | r_node[gl-1][4*gn+3];
                end
            end
        end
    end

    assign o_sum = r_node[LV-1][0];

endmodule

// ===== src/ordered_entry_table.sv =====
// top level of the ordered entry table: request decode, cell chain, read tree, result register
// depends on oet_pkg, oet_cell and oet_or_tree
//
// usage
//   slave stream (i_s_*) takes one request per transfer: read, insert, remove or clear
//   master stream (o_m_*) returns one result per request, in request order
//   insert and remove shift every later entry by one place in the cell chain in the
//   cycle the request is taken; count and status are settled in that same cycle
//   read data comes from a registered or-tree over the cells, tree_levels(DEPTH)
//   stages deep (3 for 64 entries)
//   one request at a time: no new request is taken while the read tree settles;
//   the next request is taken in the cycle its predecessor's result is loaded
//   into the output register
//   reset: fill level goes to zero, entry contents are left as they are
//   receiver stall: the result waits in the output register, one more request is
//   taken and worked on, then o_s_tready stays low until the register is free
module ordered_entry_table
    import oet_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // mode[1:0], position[9:2], entry_data[41:10]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // status[1:0], index[7:2], read_data[39:8],
                                             // fill_level[46:40]
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LV     = tree_levels(DEPTH);
    localparam int WAIT_W = $clog2(LV + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [WAIT_W-1:0]   r_wait;
    logic [CNT_W-1:0]    r_count;
    logic                r_rd;
    logic [IDX_W-1:0]    r_rd_pos;
    t_status             r_status;
    logic [INDEX_W-1:0]  r_index;
    logic                r_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    t_mode               w_mode;
    logic signed [15:0]  w_p16;
    logic signed [15:0]  w_c16;
    logic [63:0]         w_in64;
    t_status             d_status;
    logic signed [15:0]  d_idx;
    logic                d_ins;
    logic                d_rem;
    logic                d_rd;
    logic [CNT_W-1:0]    d_cnt;
    logic                s_fire;
    logic                w_load;
    t_cell_ctrl          w_ctrl;
    logic [ENTRY_BITS-1:0] w_cell_q  [DEPTH];
    logic [ENTRY_BITS-1:0] w_cell_rd [DEPTH];
    logic [ENTRY_BITS-1:0] w_sum;
    logic [63:0]         w_rd64;
    logic [15:0]         w_cnt16;

    assign w_mode  = t_mode'(i_s_tdata[1:0]);
    assign w_p16   = 16'(signed'(i_s_tdata[9:2]));
    assign w_c16   = signed'(16'(r_count));
    assign w_in64  = 64'(i_s_tdata[41:10]);
    assign w_cnt16 = 16'(r_count);

    always_comb begin
        d_status = ST_OK;
        d_idx    = '0;
        d_ins    = 1'b0;
        d_rem    = 1'b0;
        d_rd     = 1'b0;
        d_cnt    = r_count;
        unique case (w_mode)
            MODE_READ: begin
                if (w_p16 == -16'sd1) begin
                    if (w_c16 == 16'sd0) begin
                        d_status = ST_BADPOS;
                    end else begin
                        d_idx = w_c16 - 16'sd1;
                        d_rd  = 1'b1;
                    end
                end else if (w_p16 < 16'sd0 || w_p16 >= w_c16) begin
                    d_status = ST_BADPOS;
                end else begin
                    d_idx = w_p16;
                    d_rd  = 1'b1;
                end
            end
            MODE_INSERT: begin
                priority if (w_p16 != -16'sd1 && (w_p16 < 16'sd0 || w_p16 > w_c16)) begin
                    d_status = ST_BADPOS;
                end else if (r_count == CNT_W'(DEPTH)) begin
                    d_status = ST_FULL;
                end else begin
                    d_idx = (w_p16 == -16'sd1) ? w_c16 : w_p16;
                    d_ins = 1'b1;
                    d_cnt = r_count + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (w_p16 == -16'sd1) begin
                    if (w_c16 != 16'sd0) begin
                        d_idx = w_c16 - 16'sd1;
                        d_cnt = r_count - 1'b1;
                    end
                end else if (w_p16 < 16'sd0 || w_p16 >= w_c16) begin
                    d_status = ST_BADPOS;
                end else begin
                    d_idx = w_p16;
                    d_rem = 1'b1;
                    d_cnt = r_count - 1'b1;
                end
            end
            MODE_CLEAR: begin
                d_cnt = '0;
            end
        endcase
    end

    assign w_load     = (r_state == S_RUN) && (r_wait == '0) && (!r_m_valid || i_m_tready);
    assign o_s_tready = (r_state == S_IDLE) || w_load;
    assign s_fire     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_fire) n_state = S_RUN;
            S_RUN:  if (w_load && !s_fire) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wait    <= '0;
            r_count   <= '0;
            r_rd      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_fire) begin
                r_wait  <= WAIT_W'(LV);
                r_count <= d_cnt;
                r_rd    <= d_rd;
            end else if (r_state == S_RUN && r_wait != '0) begin
                r_wait <= r_wait - 1'b1;
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_rd_pos <= d_idx[IDX_W-1:0];
            r_status <= d_status;
            r_index  <= d_idx[INDEX_W-1:0];
        end
        if (w_load) begin
            r_m_tdata <= {1'b0, w_cnt16[FILL_W-1:0], w_rd64[RD_DATA_W-1:0], r_index, r_status};
        end
    end

    assign w_ctrl.ins = s_fire && d_ins;
    assign w_ctrl.rem = s_fire && d_rem;
    assign w_ctrl.rd  = r_rd;

    for (genvar gk = 0; gk < DEPTH; gk++) begin : g_cell
        logic [ENTRY_BITS-1:0] w_left;
        logic [ENTRY_BITS-1:0] w_right;
        if (gk == 0) begin : g_lo
            assign w_left = '0;
        end else begin : g_lo_n
            assign w_left = w_cell_q[gk-1];
        end
        if (gk == DEPTH - 1) begin : g_hi
            assign w_right = '0;
        end else begin : g_hi_n
            assign w_right = w_cell_q[gk+1];
        end
        oet_cell #(
            .IDX_W (IDX_W),
            .W     (ENTRY_BITS),
            .K     (gk)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_wr_pos (d_idx[IDX_W-1:0]),
            .i_rd_pos (r_rd_pos),
            .i_data   (w_in64[ENTRY_BITS-1:0]),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_q      (w_cell_q[gk]),
            .o_rd     (w_cell_rd[gk])
        );
    end

    oet_or_tree #(
        .N (DEPTH),
        .W (ENTRY_BITS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_cell_rd),
        .o_sum  (w_sum)
    );

    assign w_rd64     = 64'(w_sum);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill level above table depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_fire |=> $stable(r_count))
        else $error("fill level changed without a request transfer");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && d_ins |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("insert did not grow the table by one");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != ST_OK |-> o_m_tdata[39:2] == '0)
        else $error("error result carries index or read data");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && r_wait != '0 |-> !o_s_tready)
        else $error("request taken while read tree still settling");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for ordered_entry_table: directed and random table requests
// over the slave stream, every result checked against a predicted copy of the table
// depends on oet_pkg and the ordered_entry_table rtl
module testbench;
    import oet_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT       = 600;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TIMEOUT_UNITS = 8_000_000;

    typedef struct {
        t_status               status;
        logic [INDEX_W-1:0]    index;
        logic [RD_DATA_W-1:0]  read_data;
        logic [FILL_W-1:0]     fill_level;
    } table_result_t;

    class table_scoreboard;
        logic [ENTRY_BITS_DEF-1:0] rows [DEPTH_DEF];
        int fill_now;
        table_result_t pending_results[$];
        int errors;
        int n_requests;
        int n_results;
        int n_ok;
        int n_badpos;
        int n_full;
        int top_fill;

        function new();
            fill_now   = 0;
            errors     = 0;
            n_requests = 0;
            n_results  = 0;
            n_ok       = 0;
            n_badpos   = 0;
            n_full     = 0;
            top_fill   = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_request(input t_mode mode, input logic signed [POS_W-1:0] pos,
                                   input logic [IN_DATA_W-1:0] data);
            table_result_t r;
            int p;
            int k;
            p = pos;
            r.status    = ST_OK;
            r.index     = '0;
            r.read_data = '0;
            n_requests++;
            case (mode)
                MODE_READ: begin
                    if (p == -1) p = fill_now - 1;
                    if (p < 0 || p >= fill_now) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.index     = p[INDEX_W-1:0];
                        r.read_data = rows[p];
                    end
                end
                MODE_INSERT: begin
                    if (p == -1) p = fill_now;
                    if (p < 0 || p > fill_now) begin
                        r.status = ST_BADPOS;
                    end else if (fill_now >= DEPTH_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        for (k = fill_now; k > p; k--) rows[k] = rows[k-1];
                        rows[p] = data;
                        fill_now++;
                        r.index = p[INDEX_W-1:0];
                    end
                end
                MODE_REMOVE: begin
                    // removing the last entry of an empty table is a no-op with ok status
                    if (!(p == -1 && fill_now == 0)) begin
                        if (p == -1) p = fill_now - 1;
                        if (p < 0 || p >= fill_now) begin
                            r.status = ST_BADPOS;
                        end else begin
                            for (k = p; k + 1 < fill_now; k++) rows[k] = rows[k+1];
                            fill_now--;
                            r.index = p[INDEX_W-1:0];
                        end
                    end
                end
                MODE_CLEAR: begin
                    fill_now = 0;
                end
            endcase
            r.fill_level = fill_now[FILL_W-1:0];
            if (fill_now > top_fill) top_fill = fill_now;
            case (r.status)
                ST_OK:     n_ok++;
                ST_BADPOS: n_badpos++;
                ST_FULL:   n_full++;
                default:   ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(input logic [M_TDATA_W-1:0] tdata);
            table_result_t e;
            table_result_t got;
            got.status     = t_status'(tdata[1:0]);
            got.index      = tdata[7:2];
            got.read_data  = tdata[39:8];
            got.fill_level = tdata[46:40];
            n_results++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with no request waiting, tdata %h", $time, tdata);
                return;
            end
            e = pending_results.pop_front();
            if (got.status !== e.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            end
            if (got.index !== e.index) begin
                errors++;
                $display("%0t: index expected %0d actual %0d", $time, e.index, got.index);
            end
            if (got.read_data !== e.read_data) begin
                errors++;
                $display("%0t: read_data expected %h actual %h", $time, e.read_data,
                         got.read_data);
            end
            if (got.fill_level !== e.fill_level) begin
                errors++;
                $display("%0t: fill_level expected %0d actual %0d", $time, e.fill_level,
                         got.fill_level);
            end
        endfunction
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;  // mode[1:0], position[9:2], entry_data[41:10]
    logic                 i_m_tready = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;        // status[1:0], index[7:2], read_data[39:8],
                                            // fill_level[46:40]

    table_scoreboard sb = new();

    ordered_entry_table DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic send_request(input t_mode mode, input logic signed [POS_W-1:0] pos,
                                input logic [IN_DATA_W-1:0] data, input int gap);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W-MODE_W-POS_W-IN_DATA_W){1'b0}}, data, pos, mode};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(mode, pos, data);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // bias 0 fills the table, 1 mixes, 2 drains
    task automatic send_random_request(input int bias, input bit quiet);
        int r;
        int rp;
        int fill;
        t_mode mode;
        logic signed [POS_W-1:0] pos;
        r    = $urandom_range(0, 99);
        fill = sb.fill_now;
        case (bias)
            0:       mode = r < 78 ? MODE_INSERT : (r < 95 ? MODE_READ : MODE_REMOVE);
            1:       mode = r < 35 ? MODE_READ : (r < 65 ? MODE_INSERT :
                            (r < 96 ? MODE_REMOVE : MODE_CLEAR));
            default: mode = r < 30 ? MODE_READ : (r < 45 ? MODE_INSERT :
                            (r < 97 ? MODE_REMOVE : MODE_CLEAR));
        endcase
        rp = $urandom_range(0, 99);
        if (rp < 10)
            pos = POS_W'($urandom_range(0, 255));
        else if (rp < 25)
            pos = -8'sd1;
        else if (mode == MODE_INSERT)
            pos = POS_W'($urandom_range(0, fill));
        else
            pos = fill == 0 ? '0 : POS_W'($urandom_range(0, fill - 1));
        send_request(mode, pos, $urandom, quiet ? 0 : $urandom_range(0, 18));
    endtask

    initial begin
        int phase;
        int n;
        int guard;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table corner cases
        send_request(MODE_READ,   -1, $urandom, $urandom_range(0, 18));
        send_request(MODE_REMOVE, -1, $urandom, $urandom_range(0, 18));
        send_request(MODE_READ,    0, $urandom, $urandom_range(0, 18));
        // inserts at head, tail and middle, then out of range positions, then one more tail insert
        send_request(MODE_INSERT,  0, 32'h0000_0000, $urandom_range(0, 18));
        send_request(MODE_INSERT, -1, 32'hFFFF_FFFF, $urandom_range(0, 18));
        send_request(MODE_INSERT,  1, 32'hA5A5_A5A5, 0);
        send_request(MODE_INSERT,  4, $urandom, 0);
        send_request(MODE_INSERT, -2, $urandom, $urandom_range(0, 18));
        send_request(MODE_INSERT, 127, $urandom, 0);
        send_request(MODE_INSERT, -128, $urandom, $urandom_range(0, 18));
        send_request(MODE_INSERT,  3, 32'h5A5A_5A5A, $urandom_range(0, 18));
        // reads
        send_request(MODE_READ,   -1, $urandom, 0);
        send_request(MODE_READ,    0, $urandom, 0);
        send_request(MODE_READ,    2, $urandom, $urandom_range(0, 18));
        send_request(MODE_READ,    4, $urandom, $urandom_range(0, 18));
        send_request(MODE_READ, -128, $urandom, 0);
        send_request(MODE_READ,  127, $urandom, $urandom_range(0, 18));
        // removes
        send_request(MODE_REMOVE,  1, $urandom, 0);
        send_request(MODE_REMOVE, -1, $urandom, $urandom_range(0, 18));
        send_request(MODE_REMOVE,  2, $urandom, $urandom_range(0, 18));
        send_request(MODE_REMOVE, -5, $urandom, 0);
        // clear keeps entry bits but empties the table
        send_request(MODE_CLEAR,   0, $urandom, $urandom_range(0, 18));
        send_request(MODE_READ,   -1, $urandom, 0);
        send_request(MODE_INSERT, -1, $urandom, 0);
        send_request(MODE_READ,    0, $urandom, $urandom_range(0, 18));
        wait_all_results();

        for (phase = 0; phase < 29; phase++) begin
            if (phase == 15) wait_all_results();
            for (n = 0; n < 50; n++)
                send_random_request(phase % 4 == 3 ? 2 : (phase % 4 == 2 ? 1 : 0),
                                    phase % 5 == 4);
        end
        i_s_tvalid <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending());
        end
        repeat (10) @(posedge i_clk);

        $display("%0d requests, %0d results checked, table filled up to %0d entries",
                 sb.n_requests, sb.n_results, sb.top_fill);
        $display("predicted status: ok %0d, bad position %0d, table full %0d",
                 sb.n_ok, sb.n_badpos, sb.n_full);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        int stall;
        bit quiet;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            quiet = (sb.n_results / 64) % 3 == 2;
            if (sb.n_results == HOLD_AT && !held) begin
                // long back-pressure so the block fills and stalls its input
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            sb.check_result(o_m_tdata);
        end
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/oet_pkg.sv
src/oet_cell.sv
src/oet_or_tree.sv
src/ordered_entry_table.sv
sim/testbench.sv
